// ----- rtl/stm_pkg.sv -----
// ============================================================================
// stm_pkg: shared definitions of the subscription table manager
// Sizes, field widths, command and status codes.
// ============================================================================
`default_nettype none

package stm_pkg;

    localparam int unsigned MAX_ID     = 100;
    localparam int unsigned NUM_SLOTS  = 16;
    localparam int unsigned MAX_SUBID  = 100;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned ID_W       = 7;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned CNT_W      = 7;

    // One pair entry per (client, slot); slot is the low part of the address.
    localparam int unsigned PAIR_DEPTH = MAX_ID * NUM_SLOTS;
    localparam int unsigned PAIR_AW    = ID_W + SLOT_W;
    localparam int unsigned OWNER_W    = ID_W + SLOT_W;

    localparam logic [ID_W-1:0]  MAX_ID_C    = ID_W'(MAX_ID);
    localparam logic [ID_W-1:0]  MAX_SUBID_C = ID_W'(MAX_SUBID);
    localparam logic [CNT_W-1:0] CNT_MAX_C   = {CNT_W{1'b1}};
    localparam logic [SLOT_W-1:0] LAST_SLOT_C = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 3'd0,
        CMD_UNREGISTER = 3'd1,
        CMD_SUBSCRIBE  = 3'd2,
        CMD_UNSUB_FUNC = 3'd3,
        CMD_UNSUB_ID   = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_FREE_ID  = 3'd1,
        ST_NOT_REG     = 3'd2,
        ST_ALREADY_SUB = 3'd3,
        ST_NOT_FOUND   = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/stm_req_if.sv -----
// ============================================================================
// stm_req_if: command channel
// Valid/ready channel that carries one command per transfer.
// ============================================================================
`default_nettype none

interface stm_req_if;
    logic                          valid;
    logic                          ready;
    logic [stm_pkg::CMD_W-1:0]     cmd;
    logic [stm_pkg::ID_W-1:0]      client_id;
    logic [stm_pkg::SLOT_W-1:0]    func_slot;
    logic [stm_pkg::ID_W-1:0]      sub_ident;

    modport source (output valid, cmd, client_id, func_slot, sub_ident, input ready);
    modport sink   (input valid, cmd, client_id, func_slot, sub_ident, output ready);
endinterface

`default_nettype wire

// ----- rtl/stm_rsp_if.sv -----
// ============================================================================
// stm_rsp_if: result channel
// Valid/ready channel that carries one result per transfer.
// ============================================================================
`default_nettype none

interface stm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [stm_pkg::STATUS_W-1:0]  status;
    logic [stm_pkg::ID_W-1:0]      grant_id;
    logic                          is_registered;
    logic                          is_member;
    logic [stm_pkg::CNT_W-1:0]     member_count;
    logic                          event_valid;
    logic                          event_start;
    logic [stm_pkg::SLOT_W-1:0]    event_slot;
    logic                          last;

    modport source (output valid, status, grant_id, is_registered, is_member,
                    member_count, event_valid, event_start, event_slot, last,
                    input ready);
    modport sink   (input valid, status, grant_id, is_registered, is_member,
                    member_count, event_valid, event_start, event_slot, last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/stm_ram.sv -----
// ============================================================================
// stm_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module stm_ram #(
    parameter int unsigned DEPTH = 100,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/subscription_table_manager_top.sv -----
// ============================================================================
// subscription_table_manager_top: client and subscription table manager
// Registers clients, keeps their slot subscriptions and reports slot
// start and stop events through a small command sequencer.
// ============================================================================
//
//  channel   dir  signals
//  --------  ---  -----------------------------------------------------------
//  req       in   valid/ready, cmd, client_id, func_slot, sub_ident
//  rsp       out  valid/ready, status, grant_id, query fields, event, last
//  cfg       in   cfg_we, cfg_wdata (lifecycle enable)
//
// One command at a time; req.ready is high only while the sequencer idles.
// Register walks the client valid bits one per cycle.
// Unregister walks the 16 slot bits of the client in turn, clearing each subscribed
// slot and, with lifecycle enable set, reporting a stop event where its count hits zero.
// Each result waits in the output register; a stalled rsp holds the sequencer.
// After reset all tables are empty at once; no clearing pass is needed.
// ============================================================================
`default_nettype none

module subscription_table_manager_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stm_req_if.sink     req,
    stm_rsp_if.source   rsp,
    input  wire logic   cfg_we,
    input  wire logic   cfg_wdata
);

    localparam int unsigned ID_W   = stm_pkg::ID_W;
    localparam int unsigned SLOT_W = stm_pkg::SLOT_W;
    localparam int unsigned CNT_W  = stm_pkg::CNT_W;
    localparam int unsigned NS     = stm_pkg::NUM_SLOTS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_REG_SCAN,
        S_UNREG_ROW,
        S_UNREG_SCAN,
        S_UNREG_SUBID,
        S_UNREG_NEXT,
        S_UNREG_END,
        S_SUB_CHECK,
        S_UNSUBF_CHECK,
        S_UNSUBI_OWNER,
        S_QUERY,
        S_EVENT,
        S_FINAL
    } state_t;

    state_t state_reg, state_next;

    logic [stm_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_W-1:0]              cid_reg, cid_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [ID_W-1:0]              sid_reg, sid_next;
    logic [ID_W-1:0]              cand_reg, cand_next;
    logic [ID_W-1:0]              tries_reg, tries_next;
    logic [SLOT_W-1:0]            scan_reg, scan_next;
    logic [NS-1:0]                row_reg, row_next;
    logic [stm_pkg::MAX_ID-1:0]   client_valid_reg, client_valid_next;
    logic [stm_pkg::MAX_SUBID-1:0] subv_reg, subv_next;
    logic [CNT_W-1:0]             slot_count_reg [NS];
    logic [CNT_W-1:0]             slot_count_next [NS];
    logic [ID_W-1:0]              next_client_reg, next_client_next;
    logic [ID_W-1:0]              next_subid_reg, next_subid_next;
    logic                         lc_en_reg, lc_en_next;

    logic [stm_pkg::STATUS_W-1:0] fin_status_reg, fin_status_next;
    logic [ID_W-1:0]              fin_assigned_reg, fin_assigned_next;
    logic                         fin_isreg_reg, fin_isreg_next;
    logic                         fin_ismem_reg, fin_ismem_next;
    logic [CNT_W-1:0]             fin_cnt_reg, fin_cnt_next;
    logic                         ev_start_reg, ev_start_next;
    logic [SLOT_W-1:0]            ev_slot_reg, ev_slot_next;

    logic                         out_valid_reg, out_valid_next;
    logic [stm_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]              out_assigned_reg, out_assigned_next;
    logic                         out_isreg_reg, out_isreg_next;
    logic                         out_ismem_reg, out_ismem_next;
    logic [CNT_W-1:0]             out_cnt_reg, out_cnt_next;
    logic                         out_ev_reg, out_ev_next;
    logic                         out_evstart_reg, out_evstart_next;
    logic [SLOT_W-1:0]            out_evslot_reg, out_evslot_next;
    logic                         out_last_reg, out_last_next;

    // RAM ports
    logic                         mem_we;
    logic [ID_W-1:0]              mem_waddr;
    logic [NS-1:0]                mem_wdata, mem_rdata;
    logic                         pair_we;
    logic [stm_pkg::PAIR_AW-1:0]  pair_waddr, pair_raddr;
    logic [ID_W-1:0]              pair_wdata, pair_rdata;
    logic                         own_we;
    logic [ID_W-1:0]              own_waddr;
    logic [stm_pkg::OWNER_W-1:0]  own_wdata, own_rdata;

    logic [ID_W-1:0]   cid_m1;
    logic [ID_W-1:0]   sid_m1;
    logic              cid_in_range;
    logic              cid_ok;
    logic              sid_in_range;
    logic [SLOT_W-1:0] pair_sel;
    logic [SLOT_W-1:0] cnt_idx;
    logic [CNT_W-1:0]  cnt_cur;
    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  cnt_inc;
    logic [ID_W-1:0]   own_client;
    logic [SLOT_W-1:0] own_slot;
    logic              out_free;
    logic              accept;

    assign cid_m1       = cid_reg - ID_W'(1);
    assign sid_m1       = sid_reg - ID_W'(1);
    assign cid_in_range = (cid_reg != '0) && (cid_reg <= stm_pkg::MAX_ID_C);
    assign cid_ok       = cid_in_range && client_valid_reg[cid_m1];
    assign sid_in_range = (sid_reg != '0) && (sid_reg <= stm_pkg::MAX_SUBID_C);
    assign own_client   = own_rdata[stm_pkg::OWNER_W-1:SLOT_W];
    assign own_slot     = own_rdata[SLOT_W-1:0];
    assign out_free     = !out_valid_reg || rsp.ready;
    assign accept       = req.valid && req.ready;

    assign pair_sel   = (state_reg == S_DISPATCH) ? slot_reg : scan_reg;
    assign pair_raddr = {cid_m1, pair_sel};

    always_comb
    begin
        unique case (state_reg)
            S_UNREG_SUBID:  cnt_idx = scan_reg;
            S_UNSUBI_OWNER: cnt_idx = own_slot;
            default:        cnt_idx = slot_reg;
        endcase
    end

    assign cnt_cur = slot_count_reg[cnt_idx];
    assign cnt_dec = (cnt_cur != '0) ? cnt_cur - CNT_W'(1) : cnt_cur;
    assign cnt_inc = (cnt_cur != stm_pkg::CNT_MAX_C) ? cnt_cur + CNT_W'(1) : cnt_cur;

    stm_ram #(.DEPTH(stm_pkg::MAX_ID), .WIDTH(NS), .AW(ID_W)) u_membership (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cid_m1),
        .rdata (mem_rdata)
    );

    stm_ram #(.DEPTH(stm_pkg::PAIR_DEPTH), .WIDTH(ID_W), .AW(stm_pkg::PAIR_AW)) u_pair (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    stm_ram #(.DEPTH(stm_pkg::MAX_SUBID), .WIDTH(stm_pkg::OWNER_W), .AW(ID_W)) u_owner (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (sid_m1),
        .rdata (own_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        cid_next          = cid_reg;
        slot_next         = slot_reg;
        sid_next          = sid_reg;
        cand_next         = cand_reg;
        tries_next        = tries_reg;
        scan_next         = scan_reg;
        row_next          = row_reg;
        client_valid_next = client_valid_reg;
        subv_next         = subv_reg;
        slot_count_next   = slot_count_reg;
        next_client_next  = next_client_reg;
        next_subid_next   = next_subid_reg;
        lc_en_next        = cfg_we ? cfg_wdata : lc_en_reg;
        fin_status_next   = fin_status_reg;
        fin_assigned_next = fin_assigned_reg;
        fin_isreg_next    = fin_isreg_reg;
        fin_ismem_next    = fin_ismem_reg;
        fin_cnt_next      = fin_cnt_reg;
        ev_start_next     = ev_start_reg;
        ev_slot_next      = ev_slot_reg;

        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_assigned_next = out_assigned_reg;
        out_isreg_next    = out_isreg_reg;
        out_ismem_next    = out_ismem_reg;
        out_cnt_next      = out_cnt_reg;
        out_ev_next       = out_ev_reg;
        out_evstart_next  = out_evstart_reg;
        out_evslot_next   = out_evslot_reg;
        out_last_next     = out_last_reg;

        mem_we     = 1'b0;
        mem_waddr  = cid_m1;
        mem_wdata  = '0;
        pair_we    = 1'b0;
        pair_waddr = {cid_m1, slot_reg};
        pair_wdata = next_subid_reg;
        own_we     = 1'b0;
        own_waddr  = next_subid_reg - ID_W'(1);
        own_wdata  = {cid_reg, slot_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.cmd;
                    cid_next   = req.client_id;
                    slot_next  = req.func_slot;
                    sid_next   = req.sub_ident;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                fin_status_next   = stm_pkg::ST_OK;
                fin_assigned_next = '0;
                fin_isreg_next    = 1'b0;
                fin_ismem_next    = 1'b0;
                fin_cnt_next      = '0;
                case (cmd_reg)
                    stm_pkg::CMD_REGISTER:
                    begin
                        cand_next  = next_client_reg;
                        tries_next = '0;
                        state_next = S_REG_SCAN;
                    end
                    stm_pkg::CMD_UNREGISTER:
                    begin
                        if (cid_ok)
                        begin
                            state_next = S_UNREG_ROW;
                        end
                        else
                        begin
                            fin_status_next = stm_pkg::ST_NOT_REG;
                            state_next      = S_FINAL;
                        end
                    end
                    stm_pkg::CMD_SUBSCRIBE:
                    begin
                        if (cid_ok)
                        begin
                            state_next = S_SUB_CHECK;
                        end
                        else
                        begin
                            fin_status_next = stm_pkg::ST_NOT_REG;
                            state_next      = S_FINAL;
                        end
                    end
                    stm_pkg::CMD_UNSUB_FUNC:
                    begin
                        if (cid_ok)
                        begin
                            state_next = S_UNSUBF_CHECK;
                        end
                        else
                        begin
                            fin_status_next = stm_pkg::ST_NOT_FOUND;
                            state_next      = S_FINAL;
                        end
                    end
                    stm_pkg::CMD_UNSUB_ID:
                    begin
                        if (sid_in_range && cid_in_range && subv_reg[sid_m1])
                        begin
                            state_next = S_UNSUBI_OWNER;
                        end
                        else
                        begin
                            fin_status_next = stm_pkg::ST_NOT_FOUND;
                            state_next      = S_FINAL;
                        end
                    end
                    stm_pkg::CMD_QUERY:
                    begin
                        state_next = S_QUERY;
                    end
                    default:
                    begin
                        state_next = S_FINAL;
                    end
                endcase
            end

            S_REG_SCAN:
            begin
                if (!client_valid_reg[cand_reg - ID_W'(1)])
                begin
                    client_valid_next[cand_reg - ID_W'(1)] = 1'b1;
                    mem_we            = 1'b1;
                    mem_waddr         = cand_reg - ID_W'(1);
                    mem_wdata         = '0;
                    next_client_next  = (cand_reg >= stm_pkg::MAX_ID_C) ?
                                        ID_W'(1) : cand_reg + ID_W'(1);
                    fin_assigned_next = cand_reg;
                    state_next        = S_FINAL;
                end
                else if (tries_reg == stm_pkg::MAX_ID_C - ID_W'(1))
                begin
                    fin_status_next = stm_pkg::ST_NO_FREE_ID;
                    state_next      = S_FINAL;
                end
                else
                begin
                    cand_next  = (cand_reg >= stm_pkg::MAX_ID_C) ?
                                 ID_W'(1) : cand_reg + ID_W'(1);
                    tries_next = tries_reg + ID_W'(1);
                end
            end

            S_UNREG_ROW:
            begin
                row_next   = mem_rdata;
                scan_next  = '0;
                state_next = S_UNREG_SCAN;
            end

            // The pair read for this slot is issued here and used next cycle.
            S_UNREG_SCAN:
            begin
                if (row_reg[scan_reg])
                begin
                    state_next = S_UNREG_SUBID;
                end
                else
                begin
                    state_next = S_UNREG_NEXT;
                end
            end

            S_UNREG_SUBID:
            begin
                if ((pair_rdata != '0) && (pair_rdata <= stm_pkg::MAX_SUBID_C))
                begin
                    subv_next[pair_rdata - ID_W'(1)] = 1'b0;
                end
                slot_count_next[scan_reg] = cnt_dec;
                if ((cnt_dec == '0) && lc_en_reg)
                begin
                    ev_start_next = 1'b0;
                    ev_slot_next  = scan_reg;
                    state_next    = S_EVENT;
                end
                else
                begin
                    state_next = S_UNREG_NEXT;
                end
            end

            S_UNREG_NEXT:
            begin
                if (scan_reg == stm_pkg::LAST_SLOT_C)
                begin
                    state_next = S_UNREG_END;
                end
                else
                begin
                    scan_next  = scan_reg + SLOT_W'(1);
                    state_next = S_UNREG_SCAN;
                end
            end

            S_UNREG_END:
            begin
                client_valid_next[cid_m1] = 1'b0;
                mem_we     = 1'b1;
                mem_wdata  = '0;
                state_next = S_FINAL;
            end

            S_SUB_CHECK:
            begin
                if (mem_rdata[slot_reg])
                begin
                    fin_status_next   = stm_pkg::ST_ALREADY_SUB;
                    fin_assigned_next = pair_rdata;
                    state_next        = S_FINAL;
                end
                else
                begin
                    next_subid_next   = (next_subid_reg >= stm_pkg::MAX_SUBID_C) ?
                                        ID_W'(1) : next_subid_reg + ID_W'(1);
                    mem_we            = 1'b1;
                    mem_wdata         = mem_rdata | (NS'(1) << slot_reg);
                    pair_we           = 1'b1;
                    own_we            = 1'b1;
                    subv_next[next_subid_reg - ID_W'(1)] = 1'b1;
                    slot_count_next[slot_reg] = cnt_inc;
                    fin_assigned_next = next_subid_reg;
                    if ((cnt_inc == CNT_W'(1)) && lc_en_reg)
                    begin
                        ev_start_next = 1'b1;
                        ev_slot_next  = slot_reg;
                        state_next    = S_EVENT;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end

            S_UNSUBF_CHECK:
            begin
                if (!mem_rdata[slot_reg])
                begin
                    fin_status_next = stm_pkg::ST_NOT_FOUND;
                    state_next      = S_FINAL;
                end
                else
                begin
                    if ((pair_rdata != '0) && (pair_rdata <= stm_pkg::MAX_SUBID_C))
                    begin
                        subv_next[pair_rdata - ID_W'(1)] = 1'b0;
                    end
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata & ~(NS'(1) << slot_reg);
                    slot_count_next[slot_reg] = cnt_dec;
                    if ((cnt_dec == '0) && lc_en_reg)
                    begin
                        ev_start_next = 1'b0;
                        ev_slot_next  = slot_reg;
                        state_next    = S_EVENT;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end

            // The owner entry and the client's row were both read at dispatch.
            S_UNSUBI_OWNER:
            begin
                if (own_client != cid_reg)
                begin
                    fin_status_next = stm_pkg::ST_NOT_FOUND;
                    state_next      = S_FINAL;
                end
                else
                begin
                    subv_next[sid_m1] = 1'b0;
                    state_next        = S_FINAL;
                    if (mem_rdata[own_slot])
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata & ~(NS'(1) << own_slot);
                        slot_count_next[own_slot] = cnt_dec;
                        if ((cnt_dec == '0) && lc_en_reg)
                        begin
                            ev_start_next = 1'b0;
                            ev_slot_next  = own_slot;
                            state_next    = S_EVENT;
                        end
                    end
                end
            end

            S_QUERY:
            begin
                fin_isreg_next = cid_ok;
                fin_ismem_next = cid_ok && mem_rdata[slot_reg];
                fin_cnt_next   = cnt_cur;
                state_next     = S_FINAL;
            end

            S_EVENT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = stm_pkg::ST_OK;
                    out_assigned_next = '0;
                    out_isreg_next    = 1'b0;
                    out_ismem_next    = 1'b0;
                    out_cnt_next      = '0;
                    out_ev_next       = 1'b1;
                    out_evstart_next  = ev_start_reg;
                    out_evslot_next   = ev_slot_reg;
                    out_last_next     = 1'b0;
                    state_next        = (cmd_reg == stm_pkg::CMD_UNREGISTER) ?
                                        S_UNREG_NEXT : S_FINAL;
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = fin_status_reg;
                    out_assigned_next = fin_assigned_reg;
                    out_isreg_next    = fin_isreg_reg;
                    out_ismem_next    = fin_ismem_reg;
                    out_cnt_next      = fin_cnt_reg;
                    out_ev_next       = 1'b0;
                    out_evstart_next  = 1'b0;
                    out_evslot_next   = '0;
                    out_last_next     = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            client_valid_reg <= '0;
            subv_reg         <= '0;
            for (int i = 0; i < NS; i++)
            begin
                slot_count_reg[i] <= '0;
            end
            next_client_reg  <= ID_W'(1);
            next_subid_reg   <= ID_W'(1);
            lc_en_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= '0;
            out_assigned_reg <= '0;
            out_isreg_reg    <= 1'b0;
            out_ismem_reg    <= 1'b0;
            out_cnt_reg      <= '0;
            out_ev_reg       <= 1'b0;
            out_evstart_reg  <= 1'b0;
            out_evslot_reg   <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            client_valid_reg <= client_valid_next;
            subv_reg         <= subv_next;
            slot_count_reg   <= slot_count_next;
            next_client_reg  <= next_client_next;
            next_subid_reg   <= next_subid_next;
            lc_en_reg        <= lc_en_next;
            out_valid_reg    <= out_valid_next;
            out_status_reg   <= out_status_next;
            out_assigned_reg <= out_assigned_next;
            out_isreg_reg    <= out_isreg_next;
            out_ismem_reg    <= out_ismem_next;
            out_cnt_reg      <= out_cnt_next;
            out_ev_reg       <= out_ev_next;
            out_evstart_reg  <= out_evstart_next;
            out_evslot_reg   <= out_evslot_next;
            out_last_reg     <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        cid_reg          <= cid_next;
        slot_reg         <= slot_next;
        sid_reg          <= sid_next;
        cand_reg         <= cand_next;
        tries_reg        <= tries_next;
        scan_reg         <= scan_next;
        row_reg          <= row_next;
        fin_status_reg   <= fin_status_next;
        fin_assigned_reg <= fin_assigned_next;
        fin_isreg_reg    <= fin_isreg_next;
        fin_ismem_reg    <= fin_ismem_next;
        fin_cnt_reg      <= fin_cnt_next;
        ev_start_reg     <= ev_start_next;
        ev_slot_reg      <= ev_slot_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.grant_id      = out_assigned_reg;
    assign rsp.is_registered = out_isreg_reg;
    assign rsp.is_member     = out_ismem_reg;
    assign rsp.member_count  = out_cnt_reg;
    assign rsp.event_valid   = out_ev_reg;
    assign rsp.event_start   = out_evstart_reg;
    assign rsp.event_slot    = out_evslot_reg;
    assign rsp.last          = out_last_reg;

    a_next_client_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_client_reg != '0) && (next_client_reg <= stm_pkg::MAX_ID_C))
        else $error("client pointer left its range");

    a_next_subid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_subid_reg != '0) && (next_subid_reg <= stm_pkg::MAX_SUBID_C))
        else $error("subscription counter left its range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("command accepted while one is in progress");

    a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ev_reg) |-> !out_last_reg)
        else $error("lifecycle event marked as final result");

endmodule

`default_nettype wire
